[src/gtr_pkg.sv]
// Shared types, codes and font ROM for the glyph text renderer.
// No dependencies; imported by the renderer core.
package gtr_pkg;

	localparam logic [1:0] ACT_CHAR  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam logic [7:0] LAST_CODE  = 8'd127;

	typedef logic [47:0] glyph_t;

	localparam glyph_t FONT_ROM [96] = '{
		48'h02_00_00_00_00_00, 48'h01_FA_00_00_00_00, 48'h03_C0_00_C0_00_00,
		48'h05_24_7E_24_7E_24, 48'h04_24_D4_56_48_00, 48'h05_C6_C8_10_26_C6,
		48'h05_6C_92_6A_04_0A, 48'h01_C0_00_00_00_00, 48'h02_7C_82_00_00_00,
		48'h02_82_7C_00_00_00, 48'h05_10_7C_38_7C_10, 48'h05_10_10_7C_10_10,
		48'h02_06_07_00_00_00, 48'h04_10_10_10_10_00, 48'h02_06_06_00_00_00,
		48'h05_04_08_10_20_40, 48'h05_7C_8A_92_A2_7C, 48'h03_42_FE_02_00_00,
		48'h05_46_8A_92_92_62, 48'h05_44_92_92_92_6C, 48'h05_18_28_48_FE_08,
		48'h05_F4_92_92_92_8C, 48'h05_3C_52_92_92_8C, 48'h05_80_8E_90_A0_C0,
		48'h05_6C_92_92_92_6C, 48'h05_60_92_92_94_78, 48'h02_36_36_00_00_00,
		48'h02_36_37_00_00_00, 48'h04_10_28_44_82_00, 48'h05_24_24_24_24_24,
		48'h04_82_44_28_10_00, 48'h05_60_80_9A_90_60, 48'h05_7C_82_BA_AA_78,
		48'h05_7E_90_90_90_7E, 48'h05_FE_92_92_92_6C, 48'h05_7C_82_82_82_44,
		48'h05_FE_82_82_82_7C, 48'h05_FE_92_92_92_82, 48'h05_FE_90_90_90_80,
		48'h05_7C_82_92_92_5C, 48'h05_FE_10_10_10_FE, 48'h03_82_FE_82_00_00,
		48'h05_0C_02_02_02_FC, 48'h05_FE_10_28_44_82, 48'h04_FE_02_02_02_00,
		48'h05_FE_40_20_40_FE, 48'h05_FE_40_20_10_FE, 48'h05_7C_82_82_82_7C,
		48'h05_FE_90_90_90_60, 48'h05_7C_82_92_8C_7A, 48'h05_FE_90_90_98_66,
		48'h05_64_92_92_92_4C, 48'h05_80_80_FE_80_80, 48'h05_FC_02_02_02_FC,
		48'h05_F8_04_02_04_F8, 48'h05_FC_02_3C_02_FC, 48'h05_C6_28_10_28_C6,
		48'h05_E0_10_0E_10_E0, 48'h05_86_8A_92_A2_C2, 48'h03_FE_82_82_00_00,
		48'h05_40_20_10_08_04, 48'h03_82_82_FE_00_00, 48'h05_20_40_80_40_20,
		48'h05_02_02_02_02_02, 48'h02_C0_E0_00_00_00, 48'h04_04_2A_2A_1E_00,
		48'h04_FE_22_22_1C_00, 48'h04_1C_22_22_22_00, 48'h04_1C_22_22_FC_00,
		48'h04_1C_2A_2A_10_00, 48'h04_10_7E_90_80_00, 48'h04_18_25_25_3E_00,
		48'h04_FE_20_20_1E_00, 48'h02_BC_02_00_00_00, 48'h04_02_01_21_BE_00,
		48'h04_FE_08_14_22_00, 48'h02_FC_02_00_00_00, 48'h05_3E_20_18_20_1E,
		48'h04_3E_20_20_1E_00, 48'h04_1C_22_22_1C_00, 48'h04_3F_22_22_1C_00,
		48'h04_1C_22_22_3F_00, 48'h04_22_1E_20_10_00, 48'h04_12_2A_2A_04_00,
		48'h04_20_7C_22_04_00, 48'h04_3C_02_02_3E_00, 48'h05_38_04_02_04_38,
		48'h05_3C_06_0C_06_3C, 48'h05_22_14_08_14_22, 48'h04_39_05_06_3C_00,
		48'h04_26_2A_2A_32_00, 48'h04_10_7C_82_82_00, 48'h01_EE_00_00_00_00,
		48'h04_82_82_7C_10_00, 48'h04_40_80_40_80_00, 48'h04_60_90_90_60_00
	};

	function automatic logic [2:0] glyph_width(input logic [6:0] g);
		glyph_t r;
		r = FONT_ROM[g];
		return r[42:40];
	endfunction

	function automatic logic [7:0] glyph_col(input logic [6:0] g, input logic [2:0] j);
		glyph_t r;
		r = FONT_ROM[g];
		return 8'(r >> (6'd32 - {j, 3'b000}));
	endfunction

endpackage

[src/gtr_req_if.sv]
// Request channel of the glyph text renderer.
// Carries valid, ready and one request's fields.
interface gtr_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic              first;
	logic signed [7:0] start_x;
	logic signed [7:0] start_y;
	logic              wrap_on;
	logic [7:0]        char_code;
	logic [9:0]        store_addr;

	modport source (output valid, action, first, start_x, start_y, wrap_on, char_code,
		store_addr, input ready);
	modport sink (input valid, action, first, start_x, start_y, wrap_on, char_code,
		store_addr, output ready);
endinterface

[src/gtr_rsp_if.sv]
// Result channel of the glyph text renderer.
// Carries valid, ready and one result's fields.
interface gtr_rsp_if;
	logic              valid;
	logic              ready;
	logic [7:0]        read_data;
	logic signed [8:0] cursor_x;
	logic signed [7:0] cursor_y;
	logic              halted;

	modport source (output valid, read_data, cursor_x, cursor_y, halted, input ready);
	modport sink (input valid, read_data, cursor_x, cursor_y, halted, output ready);
endinterface

[src/glyph_text_renderer_paged_fb_core.sv]
// Glyph text renderer core: font ROM, cursor control and frame store RMW.
// Depends on gtr_pkg, gtr_req_if and gtr_rsp_if.
// One request at a time: read, clear and character requests each run to their
// result before the next is accepted, with a read-modify-write of the frame
// store per drawn glyph column; the store has one read and one write port.
// Reset: a clearing pass zeroes the store, no request taken.
module glyph_text_renderer_paged_fb_core
	import gtr_pkg::*;
#(
	parameter int FRAME_BYTES = 1024,
	parameter int MAX_COLUMNS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	gtr_req_if.sink     req,
	gtr_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(FRAME_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_COL  = 4'd3;
	localparam logic [3:0] S_RD0  = 4'd4;
	localparam logic [3:0] S_RD1  = 4'd5;
	localparam logic [3:0] S_WR1  = 4'd6;
	localparam logic [3:0] S_RDB  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]        state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic              clr_rsp_q;
	logic [7:0]        dw_q;
	logic [6:0]        dh_q;
	logic signed [8:0] col_q;
	logic signed [7:0] row_q;
	logic              wrap_q, stop_q;
	logic [6:0]        gidx_q;
	logic [2:0]        cols_q, j_q;
	logic [7:0]        data_q;
	logic              rinr_q;
	logic [AW-1:0]     addr0_q, addr1_q;
	logic              we0_q, we1_q;
	logic [7:0]        bits0_q, bits1_q;
	logic [7:0]        mem [FRAME_BYTES];
	logic [7:0]        rdata_q;
	logic              ovalid_q;
	logic [7:0]        ordata_q;
	logic signed [8:0] ocx_q;
	logic signed [7:0] ocy_q;
	logic              ohalt_q;

	logic [7:0]        w;
	logic signed [9:0] w10, h10, col10, row10, row8;
	logic [8:0]        ncol;
	logic              at_edge, room, wrap_hit, last_col;
	logic [7:0]        raw, rev;
	logic [15:0]       word, vmask;
	logic signed [9:0] ybase, y;
	logic [5:0]        p1;
	logic [12:0]       a0, a1;
	logic              col_ok, g_we0, g_we1;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [7:0]        wr_data;
	logic              mem_we;
	logic              cfg_wr, accept, code_ok;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (paddr[2] == CFG_HEIGHT) ? {25'd0, dh_q} : {24'd0, dw_q};
	assign req.ready = (state_q == S_IDLE);
	assign accept  = req.valid && req.ready;
	assign rsp.valid     = ovalid_q;
	assign rsp.read_data = ordata_q;
	assign rsp.cursor_x  = ocx_q;
	assign rsp.cursor_y  = ocy_q;
	assign rsp.halted    = ohalt_q;

	assign w      = (dw_q > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : dw_q;
	assign w10    = $signed({2'b00, w});
	assign h10    = $signed({3'b000, dh_q});
	assign col10  = {col_q[8], col_q};
	assign row10  = {{2{row_q[7]}}, row_q};
	assign row8   = row10 + 10'sd8;
	assign ncol   = col_q + 9'sd1;
	assign at_edge = $signed({ncol[8], ncol}) >= w10;
	assign room   = row8 < h10;
	assign wrap_hit = wrap_q && ((col10 + $signed({7'd0, cols_q}) + 10'sd1) >= w10);
	assign last_col = (j_q == cols_q);
	assign code_ok = (req.char_code >= FIRST_CODE) && (req.char_code <= LAST_CODE);

	always_comb begin
		raw = glyph_col(gidx_q, j_q);
		for (int i = 0; i < 8; i++) begin
			rev[i] = raw[7-i];
		end
		ybase = {row10[9:3], 3'b000};
		for (int i = 0; i < 16; i++) begin
			y = ybase + 10'(i);
			vmask[i] = (y >= 10'sd0) && (y < h10);
		end
		word   = ({8'd0, rev} << row_q[2:0]) & vmask;
		col_ok = (col10 >= 10'sd0) && (col10 < w10);
		p1     = {row_q[7], row_q[7:3]} + 6'd1;
		a0     = 13'(row_q[6:3]) * 13'(w) + 13'(col_q[6:0]);
		a1     = 13'(p1[4:0]) * 13'(w) + 13'(col_q[6:0]);
		g_we0  = col_ok && !row_q[7] && (a0 < 13'(FRAME_BYTES)) && (word[7:0] != 8'd0);
		g_we1  = col_ok && !p1[5] && (a1 < 13'(FRAME_BYTES)) && (word[15:8] != 8'd0);
	end

	always_comb begin
		unique case (state_q)
			S_RD0:   rd_addr = addr0_q;
			S_RD1:   rd_addr = addr1_q;
			default: rd_addr = req.store_addr[AW-1:0];
		endcase
		mem_we  = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = 8'd0;
		unique case (state_q)
			S_CLR: mem_we = 1'b1;
			S_RD1: begin
				mem_we  = we0_q;
				wr_addr = addr0_q;
				wr_data = rdata_q | bits0_q;
			end
			S_WR1: begin
				mem_we  = we1_q;
				wr_addr = addr1_q;
				wr_data = rdata_q | bits1_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COL) begin
			addr0_q <= a0[AW-1:0];
			addr1_q <= a1[AW-1:0];
			we0_q   <= g_we0;
			we1_q   <= g_we1;
			bits0_q <= word[7:0];
			bits1_q <= word[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= 8'd128;
			dh_q <= 7'd64;
		end else if (cfg_wr) begin
			if (paddr[2] == CFG_WIDTH) begin
				dw_q <= pwdata[7:0];
			end else begin
				dh_q <= pwdata[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			clr_rsp_q <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			wrap_q    <= 1'b0;
			stop_q    <= 1'b0;
			gidx_q    <= '0;
			cols_q    <= '0;
			j_q       <= '0;
			data_q    <= '0;
			rinr_q    <= 1'b0;
			ovalid_q  <= 1'b0;
			ordata_q  <= '0;
			ocx_q     <= '0;
			ocy_q     <= '0;
			ohalt_q   <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready && state_q != S_DONE) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q <= 8'd0;
						unique case (req.action)
							ACT_CHAR: begin
								if (req.first) begin
									col_q  <= {req.start_x[7], req.start_x};
									row_q  <= req.start_y;
									wrap_q <= req.wrap_on;
									stop_q <= 1'b0;
								end
								gidx_q <= code_ok ? 7'(req.char_code - FIRST_CODE) : 7'd0;
								cols_q <= code_ok ? glyph_width(7'(req.char_code - FIRST_CODE))
									: 3'd0;
								j_q    <= 3'd0;
								state_q <= (!req.first && stop_q) ? S_DONE : S_CHK;
							end
							ACT_CLEAR: begin
								clr_cnt_q <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLR;
							end
							ACT_READ: begin
								rinr_q  <= {1'b0, req.store_addr} < 11'(FRAME_BYTES);
								state_q <= S_RDB;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(FRAME_BYTES - 1)) begin
						state_q   <= clr_rsp_q ? S_DONE : S_IDLE;
						clr_rsp_q <= 1'b0;
					end
				end
				S_RDB: begin
					data_q  <= rinr_q ? rdata_q : 8'd0;
					state_q <= S_DONE;
				end
				S_CHK: begin
					if (wrap_hit) begin
						if (room) begin
							col_q   <= '0;
							row_q   <= 8'(row8);
							state_q <= S_COL;
						end else begin
							stop_q  <= 1'b1;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_COL;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_WR1;
				S_COL, S_WR1: begin
					if (state_q == S_COL && !last_col) begin
						state_q <= S_RD0;
					end else begin
						if (at_edge && !wrap_q) begin
							col_q   <= ncol;
							stop_q  <= 1'b1;
							state_q <= S_DONE;
						end else if (at_edge && !room) begin
							col_q   <= ncol;
							state_q <= S_DONE;
						end else begin
							if (at_edge) begin
								col_q <= '0;
								row_q <= 8'(row8);
							end else begin
								col_q <= ncol;
							end
							if (last_col) begin
								state_q <= S_DONE;
							end else begin
								j_q     <= j_q + 3'd1;
								state_q <= S_COL;
							end
						end
					end
				end
				S_DONE: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						ordata_q <= data_q;
						ocx_q    <= col_q;
						ocy_q    <= row_q;
						ohalt_q  <= stop_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/gtr_check.sv]
// Port-level checks for the glyph text renderer core.
// Bound to glyph_text_renderer_paged_fb_core; no package use.
module gtr_check (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [7:0]        rsp_read_data,
	input logic signed [8:0] rsp_cursor_x,
	input logic              rsp_halted
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
		&& $stable(rsp_cursor_x) && $stable(rsp_halted))
		else $error("result changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cursor_x <= 9'sd128)
		else $error("cursor column beyond panel limit");
endmodule

bind glyph_text_renderer_paged_fb_core gtr_check u_gtr_check (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_cursor_x(rsp.cursor_x),
	.rsp_halted(rsp.halted)
);

[tb/sv/gtr_checker.sv]
`timescale 1ns / 100ps
// Checker for the glyph text renderer: keeps its own copy of the frame store,
// cursor and panel size, predicts each result and compares it with the block.
// Depends on gtr_pkg, gtr_req_if and gtr_rsp_if.
module gtr_checker
	import gtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	gtr_req_if          req,
	gtr_rsp_if          rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending
);
	localparam int STORE_BYTES = 1024;
	localparam int COL_LIMIT   = 128;

	typedef struct packed {
		logic [7:0]        read_data;
		logic signed [8:0] cursor_x;
		logic signed [7:0] cursor_y;
		logic              halted;
	} result_t;

	logic [7:0] pixels [STORE_BYTES];
	int         col_pos;
	int         row_pos;
	bit         wrapping;
	bit         stopped;
	int         panel_w;
	int         panel_h;
	result_t    result_q [$];

	function automatic int width_used();
		return (panel_w > COL_LIMIT) ? COL_LIMIT : panel_w;
	endfunction

	function automatic void plot_column(logic [7:0] bits);
		int w;
		int y;
		int addr;
		w = width_used();
		if (col_pos < 0 || col_pos >= w)
			return;
		for (int k = 0; k < 8; k++) begin
			y = row_pos + k;
			if (!bits[7 - k] || y < 0 || y >= panel_h)
				continue;
			addr = (y >>> 3) * w + col_pos;
			if (addr >= STORE_BYTES)
				continue;
			pixels[addr][y & 7] = 1'b1;
		end
	endfunction

	function automatic void draw_glyph(logic [7:0] code);
		int     w;
		int     ncols;
		glyph_t g;
		w = width_used();
		ncols = 0;
		g = '0;
		if (code >= FIRST_CODE && code <= LAST_CODE) begin
			g = FONT_ROM[code - FIRST_CODE];
			ncols = int'(g[42:40]);
		end
		if (wrapping && col_pos + ncols + 1 >= w) begin
			if (row_pos + 8 < panel_h) begin
				col_pos = 0;
				row_pos += 8;
			end else begin
				stopped = 1'b1;
				return;
			end
		end
		for (int j = 0; j <= ncols; j++) begin
			plot_column(j < ncols ? 8'(g >> (32 - 8 * j)) : 8'h00);
			col_pos++;
			if (col_pos >= w) begin
				if (!wrapping) begin
					stopped = 1'b1;
					return;
				end
				if (row_pos + 8 < panel_h) begin
					col_pos = 0;
					row_pos += 8;
				end else begin
					return;
				end
			end
		end
	endfunction

	function automatic result_t predict_result();
		result_t r;
		r.read_data = '0;
		case (req.action)
			ACT_CHAR: begin
				if (req.first) begin
					col_pos = int'(req.start_x);
					row_pos = int'(req.start_y);
					wrapping = req.wrap_on;
					stopped = 1'b0;
				end
				if (!stopped)
					draw_glyph(req.char_code);
			end
			ACT_CLEAR: begin
				foreach (pixels[i])
					pixels[i] = '0;
			end
			ACT_READ: begin
				if (req.store_addr < STORE_BYTES)
					r.read_data = pixels[req.store_addr];
			end
			default: ;
		endcase
		r.cursor_x = 9'(col_pos);
		r.cursor_y = 8'(row_pos);
		r.halted = stopped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			foreach (pixels[i])
				pixels[i] = '0;
			col_pos = 0;
			row_pos = 0;
			wrapping = 1'b0;
			stopped = 1'b0;
			panel_w = 128;
			panel_h = 64;
			result_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == CFG_HEIGHT)
					panel_h = int'(pwdata[6:0]);
				else
					panel_w = int'(pwdata[7:0]);
			end
			if (req.valid && req.ready)
				result_q.push_back(predict_result());
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: read_data %0h cursor_x %0d",
						rsp.read_data, rsp.cursor_x);
					errors++;
				end else begin
					exp_r = result_q.pop_front();
					if (rsp.read_data !== exp_r.read_data) begin
						$error("read_data expected %0h actual %0h", exp_r.read_data,
							rsp.read_data);
						errors++;
					end
					if (rsp.cursor_x !== exp_r.cursor_x) begin
						$error("cursor_x expected %0d actual %0d", exp_r.cursor_x,
							rsp.cursor_x);
						errors++;
					end
					if (rsp.cursor_y !== exp_r.cursor_y) begin
						$error("cursor_y expected %0d actual %0d", exp_r.cursor_y,
							rsp.cursor_y);
						errors++;
					end
					if (rsp.halted !== exp_r.halted) begin
						$error("halted expected %0b actual %0b", exp_r.halted, rsp.halted);
						errors++;
					end
				end
			end
		end
		pending = result_q.size();
	end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the glyph text renderer testbench: clock, reset, APB setup, request
// stimulus with idle and stall phases, and the verdict from gtr_checker.
// Depends on gtr_pkg, gtr_req_if, gtr_rsp_if, gtr_checker and the core.
module testbench;
	import gtr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          rsp_stall_pct;
	bit          hold_req;
	bit          hold_taken;
	int          hold_left;
	int          str_left;

	gtr_req_if req ();
	gtr_rsp_if rsp ();

	glyph_text_renderer_paged_fb_core u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gtr_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		rsp.ready = 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
	end

	// hold off the receiver once for a long stretch
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	task automatic send(logic [1:0] act, logic fst, logic [7:0] sx, logic [7:0] sy,
		logic wr, logic [7:0] code, logic [9:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.first <= fst;
		req.start_x <= sx;
		req.start_y <= sy;
		req.wrap_on <= wr;
		req.char_code <= code;
		req.store_addr <= idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		req.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (30) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic char_req(logic fst, logic [7:0] sx, logic [7:0] sy, logic wr,
		logic [7:0] code);
		send(ACT_CHAR, fst, sx, sy, wr, code, 10'($urandom));
	endtask

	task automatic random_req(int w, int h);
		int  pick;
		logic [7:0] code;
		pick = $urandom_range(999);
		if (pick < 15) begin
			send(ACT_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom), 10'($urandom));
		end else if (pick < 220) begin
			send(ACT_READ, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom), ($urandom_range(3) == 0) ? 10'($urandom)
				: 10'($urandom_range((w * h) / 8 - 1)));
		end else begin
			code = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127, 32));
			if (str_left == 0) begin
				str_left = $urandom_range(30, 1);
				send(ACT_CHAR, 1'b1,
					($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(w - 1)),
					($urandom_range(7) == 0) ? 8'($urandom)
					: 8'($urandom_range(h / 8 - 1) * 8 + (($urandom_range(3) == 0)
					? $urandom_range(7) : 0)),
					1'($urandom_range(3) != 0), code, 10'($urandom));
			end else begin
				send(ACT_CHAR, ($urandom_range(19) == 0), 8'($urandom), 8'($urandom),
					1'($urandom), code, 10'($urandom));
			end
			str_left--;
		end
	endtask

	int cfg_w [6] = '{128, 1, 37, 128, 64, 100};
	int cfg_h [6] = '{64, 8, 24, 8, 64, 40};

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.action = ACT_CHAR;
		req.first = 1'b0;
		req.start_x = '0;
		req.start_y = '0;
		req.wrap_on = 1'b0;
		req.char_code = '0;
		req.store_addr = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_req = 1'b0;
		str_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, wrap, halt, bottom edge, odd codes, reads, clear
		char_req(1'b1, 8'd0, 8'd0, 1'b0, 8'd65);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd127);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd0);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd31);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd128);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd255);
		char_req(1'b1, 8'h80, 8'h80, 1'b0, 8'd77);
		char_req(1'b1, 8'h7F, 8'h7F, 1'b1, 8'd32);
		char_req(1'b1, 8'd124, 8'd3, 1'b0, 8'd87);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd87);
		char_req(1'b1, 8'd120, 8'd0, 1'b1, 8'd72);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd72);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd72);
		char_req(1'b1, 8'd125, 8'd56, 1'b1, 8'd77);
		char_req(1'b0, 8'd0, 8'd0, 1'b0, 8'd33);
		char_req(1'b1, 8'hFE, 8'hFC, 1'b0, 8'd64);
		send(ACT_READ, 1'b0, '0, '0, 1'b0, '0, 10'd0);
		send(ACT_READ, 1'b0, '0, '0, 1'b0, '0, 10'd1);
		send(ACT_READ, 1'b1, 8'hFF, 8'hFF, 1'b1, 8'hFF, 10'd1023);
		send(ACT_READ, 1'b0, '0, '0, 1'b0, '0, 10'd248);
		send(ACT_CLEAR, 1'b1, 8'hFF, 8'hFF, 1'b1, 8'hFF, 10'h3FF);
		send(ACT_READ, 1'b0, '0, '0, 1'b0, '0, 10'd0);

		for (int p = 0; p < 6; p++) begin
			apb_write(3'd0, 32'(cfg_w[p]));
			apb_write(3'd4, 32'(cfg_h[p]));
			str_left = 0;
			for (int n = 0; n < 115; n++) begin
				case ((n / 29 + p) % 4)
					0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
					1: begin send_idle_pct = 85; rsp_stall_pct = 0; end
					2: begin send_idle_pct = 0; rsp_stall_pct = 85; end
					default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
				endcase
				if (p == 1 && n == 40) begin
					send_idle_pct = 0;
					hold_req <= 1'b1;
				end
				random_req(cfg_w[p], cfg_h[p]);
			end
		end
		req.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("glyph_text_renderer_paged_fb_core: match");
		else
			$display("glyph_text_renderer_paged_fb_core: mismatch");
		$finish;
	end

	initial begin
		#8000000;
		$display("glyph_text_renderer_paged_fb_core: mismatch");
		$finish;
	end
endmodule
